// ===== hw/rtl/lvnt_pkg.sv =====
// Shared constants, types and helpers for the lattice value noise turbulence block.
package lvnt_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int MAX_OCTAVES = 8;
    localparam int LVL_W       = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W       = 34 + MAX_OCTAVES + 4;
    localparam int TURB_SH     = 15 + MAX_OCTAVES - 1;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_NOISE = 3'd1;
    localparam logic [2:0] OP_VEC   = 3'd2;
    localparam logic [2:0] OP_GRAD  = 3'd3;
    localparam logic [2:0] OP_TURB  = 3'd4;
    localparam logic [2:0] OP_VTURB = 3'd5;

    localparam logic [8:0]  PRIME_X = 9'd173;
    localparam logic [8:0]  PRIME_Y = 9'd263;
    localparam logic [8:0]  PRIME_Z = 9'd337;
    localparam logic [23:0] PHI_LO  = 24'(48'd173961077608896);
    localparam logic [23:0] PHI_HI  = 24'(48'd173961077608896 >> 24);
    localparam logic signed [39:0] STEP_Q16 = 40'sd6554;

    typedef enum logic [2:0] {
        K_LOAD,
        K_NOISE,
        K_VEC,
        K_GRAD,
        K_TURB,
        K_VTURB,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         last_sub;
        logic [LVL_W-1:0]   levels;
        logic [8:0]         table_index;
        logic signed [15:0] table_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_cmd;

    function automatic logic [8:0] prime_of(input logic [1:0] axis);
        logic [8:0] p;
        case (axis)
            2'd0:    p = PRIME_X;
            2'd1:    p = PRIME_Y;
            default: p = PRIME_Z;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/lvnt_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
module lvnt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_op,
    input  logic [8:0]          i_table_index,
    input  logic signed [15:0]  i_table_value,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic [3:0]          i_octaves,
    output logic                o_cmd_valid,
    output lvnt_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_pop
);

    lvnt_pkg::t_cmd r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    lvnt_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_cmd.table_index = i_table_index;
        w_cmd.table_value = i_table_value;
        w_cmd.coord_x     = i_coord_x;
        w_cmd.coord_y     = i_coord_y;
        w_cmd.coord_z     = i_coord_z;
        if (int'(i_octaves) > lvnt_pkg::MAX_OCTAVES) begin
            w_cmd.levels = lvnt_pkg::LVL_W'(lvnt_pkg::MAX_OCTAVES);
        end else begin
            w_cmd.levels = lvnt_pkg::LVL_W'(i_octaves);
        end
        unique case (i_op)
            lvnt_pkg::OP_LOAD: begin
                w_cmd.kind = lvnt_pkg::K_LOAD;     w_cmd.last_sub = 2'd0;
            end
            lvnt_pkg::OP_NOISE: begin
                w_cmd.kind = lvnt_pkg::K_NOISE;    w_cmd.last_sub = 2'd0;
            end
            lvnt_pkg::OP_VEC: begin
                w_cmd.kind = lvnt_pkg::K_VEC;      w_cmd.last_sub = 2'd2;
            end
            lvnt_pkg::OP_GRAD: begin
                w_cmd.kind = lvnt_pkg::K_GRAD;     w_cmd.last_sub = 2'd3;
            end
            lvnt_pkg::OP_TURB: begin
                w_cmd.kind = (i_octaves == 4'd0) ? lvnt_pkg::K_NOP : lvnt_pkg::K_TURB;
                w_cmd.last_sub = 2'd0;
            end
            lvnt_pkg::OP_VTURB: begin
                w_cmd.kind = (i_octaves == 4'd0) ? lvnt_pkg::K_NOP : lvnt_pkg::K_VTURB;
                w_cmd.last_sub = 2'd2;
            end
            default: begin
                w_cmd.kind = lvnt_pkg::K_NOP;      w_cmd.last_sub = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cmd;
                r_wr      <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/lvnt_back.sv =====
// Back end: noise table, hash and blend sequencer, accumulation and result register.
module lvnt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  lvnt_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_value_x,
    output logic signed [31:0]  o_value_y,
    output logic signed [31:0]  o_value_z
);

    typedef enum logic [2:0] {
        S_IDLE, S_POINT, S_HASH, S_READ, S_LERP, S_ACCUM, S_DONE
    } t_state;

    localparam logic signed [39:0] OFF_A0 = 40'sd173 <<< 16;
    localparam logic signed [39:0] OFF_A1 = 40'sd263 <<< 16;
    localparam logic signed [39:0] OFF_A2 = 40'sd337 <<< 16;
    localparam logic signed [39:0] OFF_B0 = 40'sd436 <<< 16;
    localparam logic signed [39:0] OFF_B1 = 40'sd600 <<< 16;
    localparam logic signed [39:0] OFF_B2 = 40'sd510 <<< 16;

    t_state                          r_state;
    logic [3:0]                      r_cnt;
    lvnt_pkg::t_cmd                  r_cmd;
    logic signed [39:0]              r_base [3];
    logic signed [39:0]              r_pt   [3];
    logic [1:0]                      r_sub;
    logic [lvnt_pkg::LVL_W-1:0]      r_lvl;
    logic [47:0]                     r_f;
    logic [8:0]                      r_h    [6];
    logic [16:0]                     r_w    [3];
    logic signed [15:0]              r_c    [8];
    logic signed [33:0]              r_ax   [4];
    logic signed [33:0]              r_ay   [2];
    logic signed [33:0]              r_n;
    logic signed [33:0]              r_cen;
    logic signed [31:0]              r_res  [3];
    logic signed [lvnt_pkg::ACC_W-1:0] r_acc [3];
    logic                            r_ovalid;
    logic signed [31:0]              r_oval [3];
    logic [15:0]                     r_mem  [lvnt_pkg::TABLE_DEPTH];
    logic [15:0]                     r_rdata;

    logic signed [39:0]              w_pt   [3];
    logic [1:0]                      w_axis;
    logic                            w_off;
    logic signed [24:0]              w_i;
    logic signed [49:0]              w_plo;
    logic signed [49:0]              w_phi;
    logic [47:0]                     w_f;
    logic [56:0]                     w_hp;
    logic [15:0]                     w_fr;
    logic                            w_hi;
    logic [16:0]                     w_m;
    logic [33:0]                     w_sq;
    logic [16:0]                     w_bend;
    logic [10:0]                     w_sum;
    logic [lvnt_pkg::TABLE_AW-1:0]   w_raddr;
    logic signed [53:0]              w_la;
    logic signed [53:0]              w_lb;
    logic [16:0]                     w_lw;
    logic signed [53:0]              w_lres;
    logic signed [33:0]              w_nsh;
    logic signed [38:0]              w_grad;
    logic signed [38:0]              w_gsh;
    logic                            w_turb;
    logic                            w_load;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign w_load    = o_cmd_pop && (i_cmd.kind == lvnt_pkg::K_LOAD);
    assign w_turb    = (r_cmd.kind == lvnt_pkg::K_TURB) || (r_cmd.kind == lvnt_pkg::K_VTURB);
    assign o_valid   = r_ovalid;
    assign o_value_x = r_oval[0];
    assign o_value_y = r_oval[1];
    assign o_value_z = r_oval[2];

    always_comb begin
        w_pt[0] = r_base[0];
        w_pt[1] = r_base[1];
        w_pt[2] = r_base[2];
        if (r_cmd.kind == lvnt_pkg::K_VEC || r_cmd.kind == lvnt_pkg::K_VTURB) begin
            if (r_sub == 2'd1) begin
                w_pt[0] = r_base[1] + OFF_A0;
                w_pt[1] = r_base[0] + OFF_A1;
                w_pt[2] = r_base[2] + OFF_A2;
            end else if (r_sub == 2'd2) begin
                w_pt[0] = r_base[1] + OFF_B0;
                w_pt[1] = r_base[0] + OFF_B1;
                w_pt[2] = r_base[2] + OFF_B2;
            end
        end else if (r_cmd.kind == lvnt_pkg::K_GRAD) begin
            case (r_sub)
                2'd1:    w_pt[0] = r_base[0] + lvnt_pkg::STEP_Q16;
                2'd2:    w_pt[1] = r_base[1] + lvnt_pkg::STEP_Q16;
                2'd3:    w_pt[2] = r_base[2] + lvnt_pkg::STEP_Q16;
                default: w_pt[0] = r_base[0];
            endcase
        end
    end

    always_comb begin
        w_axis = r_cnt[3:2];
        w_off  = r_cnt[1];
        w_i    = 25'(signed'(r_pt[w_axis][39:16])) + 25'(w_off);
        w_plo  = 50'(w_i) * 50'(signed'({1'b0, lvnt_pkg::PHI_LO}));
        w_phi  = 50'(w_i) * 50'(signed'({1'b0, lvnt_pkg::PHI_HI}));
        w_f    = w_plo[47:0] + {w_phi[23:0], 24'd0};
        w_hp   = 57'(lvnt_pkg::prime_of(w_axis)) * 57'(r_f);
        w_fr   = r_pt[w_axis][15:0];
        w_hi   = (w_fr > 16'd32768);
        w_m    = w_hi ? (17'd65536 - 17'(w_fr)) : 17'(w_fr);
        w_sq   = 34'(w_m) * 34'(w_m);
        w_bend = w_hi ? (17'd65536 - w_sq[31:15]) : w_sq[31:15];
    end

    always_comb begin
        w_sum   = 11'(r_h[{2'd0, r_cnt[0]}]) + 11'(r_h[{2'd1, r_cnt[2]}])
                + 11'(r_h[{2'd2, r_cnt[1]}]);
        w_raddr = w_sum[lvnt_pkg::TABLE_AW-1:0];
    end

    always_comb begin
        if (r_cnt < 4'd4) begin
            w_la = 54'(r_c[{r_cnt[1:0], 1'b0}]);
            w_lb = 54'(r_c[{r_cnt[1:0], 1'b1}]);
            w_lw = r_w[0];
        end else if (r_cnt < 4'd6) begin
            w_la = 54'(r_ax[{1'b0, r_cnt[0]}]);
            w_lb = 54'(r_ax[{1'b1, r_cnt[0]}]);
            w_lw = r_w[1];
        end else begin
            w_la = 54'(r_ay[0]);
            w_lb = 54'(r_ay[1]);
            w_lw = r_w[2];
        end
        w_lres = (w_la <<< 16) + (w_lb - w_la) * 54'(signed'({1'b0, w_lw}));
        w_nsh  = r_n >>> 15;
        w_grad = (39'(r_n) - 39'(r_cen)) * 39'sd10;
        w_gsh  = w_grad >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[lvnt_pkg::TABLE_AW'(i_cmd.table_index)] <= i_cmd.table_value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= 4'd0;
            r_sub    <= 2'd0;
            r_lvl    <= '0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd     <= i_cmd;
                        r_sub     <= 2'd0;
                        r_lvl     <= '0;
                        r_base[0] <= 40'(i_cmd.coord_x);
                        r_base[1] <= 40'(i_cmd.coord_y);
                        r_base[2] <= 40'(i_cmd.coord_z);
                        for (int k = 0; k < 3; k++) begin
                            r_res[k] <= '0;
                            r_acc[k] <= '0;
                        end
                        if (i_cmd.kind == lvnt_pkg::K_LOAD || i_cmd.kind == lvnt_pkg::K_NOP) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_POINT;
                        end
                    end
                end
                S_POINT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pt[k] <= w_pt[k];
                    end
                    r_cnt   <= 4'd0;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    if (!r_cnt[0]) begin
                        r_f <= w_f;
                        if (!w_off) begin
                            r_w[w_axis] <= w_bend;
                        end
                    end else begin
                        r_h[r_cnt[3:1]] <= w_hp[56:48];
                    end
                    if (r_cnt == 4'd11) begin
                        r_cnt   <= 4'd0;
                        r_state <= S_READ;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_READ: begin
                    if (r_cnt != 4'd0) begin
                        r_c[3'(r_cnt - 4'd1)] <= r_rdata;
                    end
                    if (r_cnt == 4'd8) begin
                        r_cnt   <= 4'd0;
                        r_state <= S_LERP;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_LERP: begin
                    if (r_cnt < 4'd4) begin
                        r_ax[r_cnt[1:0]] <= w_lres[33:0];
                    end else if (r_cnt < 4'd6) begin
                        r_ay[r_cnt[0]] <= w_lres[49:16];
                    end else begin
                        r_n <= w_lres[49:16];
                    end
                    if (r_cnt == 4'd6) begin
                        r_cnt   <= 4'd0;
                        r_state <= S_ACCUM;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_ACCUM: begin
                    case (r_cmd.kind) inside
                        lvnt_pkg::K_NOISE, lvnt_pkg::K_VEC: begin
                            r_res[r_sub] <= 32'(w_nsh);
                        end
                        lvnt_pkg::K_GRAD: begin
                            if (r_sub == 2'd0) begin
                                r_cen <= r_n;
                            end else begin
                                r_res[r_sub - 2'd1] <= 32'(w_gsh);
                            end
                        end
                        default: begin
                            r_acc[r_sub] <= r_acc[r_sub] + (lvnt_pkg::ACC_W'(r_n)
                                <<< (lvnt_pkg::MAX_OCTAVES - 1 - int'(r_lvl)));
                        end
                    endcase
                    if (r_sub != r_cmd.last_sub) begin
                        r_sub   <= r_sub + 2'd1;
                        r_state <= S_POINT;
                    end else if (w_turb && (r_lvl + lvnt_pkg::LVL_W'(1)) < r_cmd.levels) begin
                        r_sub <= 2'd0;
                        r_lvl <= r_lvl + lvnt_pkg::LVL_W'(1);
                        for (int k = 0; k < 3; k++) begin
                            r_base[k] <= r_base[k] <<< 1;
                        end
                        r_state <= S_POINT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            r_oval[k] <= w_turb ? 32'(r_acc[k] >>> lvnt_pkg::TURB_SH)
                                                : r_res[k];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/lattice_value_noise_turbulence.sv =====
// Top level of the 3-D lattice value noise and turbulence block.
//
// Input channel (i_valid / o_stall): one transaction per item. i_op selects
// a table load, noise, vector noise, gradient, turbulence or vector
// turbulence. Output channel (o_valid / i_stall): one transaction per item,
// carrying o_value_x/y/z in Q16.16; unused components are zero.
// A two-entry command queue sits between the front end and the evaluation
// engine, and a result register sits at the output, so input is taken while
// a result waits.
// A load or an unused op goes from the command pop straight to the result.
// Each noise evaluation in the engine runs point setup, six lattice hashes
// on shared multipliers, eight reads of the noise table, seven blends on
// the shared blend multiplier and accumulation, in that order. Vector noise
// needs 3 evaluations, a gradient 4, turbulence one per octave and vector
// turbulence 3 per octave.
// The engine pops the next command only after it has written the last
// result, so items are handled one at a time and in order.
// Reset empties the queue and the result register; table contents are
// undefined until loaded. While i_stall is high the result holds and the
// engine waits with the next result, then the queue fills and o_stall rises.
module lattice_value_noise_turbulence (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_op,
    input  logic [8:0]          i_table_index,
    input  logic signed [15:0]  i_table_value,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic [3:0]          i_octaves,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_value_x,
    output logic signed [31:0]  o_value_y,
    output logic signed [31:0]  o_value_z
);

    logic           w_cmd_valid;
    lvnt_pkg::t_cmd w_cmd;
    logic           w_cmd_pop;

    lvnt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_octaves     (i_octaves),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    lvnt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_x   (o_value_x),
        .o_value_y   (o_value_y),
        .o_value_z   (o_value_z)
    );

endmodule

// ===== tb/sv/tb_lattice_value_noise_turbulence.sv =====
// Self-checking testbench for the lattice value noise turbulence block.
`timescale 1ns / 1ps

module tb_lattice_value_noise_turbulence;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam longint unsigned PHI48 = 64'd173961077608896;
    localparam longint unsigned FRAC48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]         op;
        logic [8:0]         idx;
        logic signed [15:0] val;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [3:0]         oct;
    } t_noise_req;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_noise_res;

    typedef struct {
        t_noise_req req;
        bit         typed;
        t_noise_res res;
    } t_vector_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_op = '0;
    logic [8:0]         i_table_index = '0;
    logic signed [15:0] i_table_value = '0;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    logic [3:0]         i_octaves = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_value_x;
    logic signed [31:0] o_value_y;
    logic signed [31:0] o_value_z;

    logic signed [15:0] value_table [lvnt_pkg::TABLE_DEPTH];
    t_noise_res         pending_values [$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    lattice_value_noise_turbulence dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint wrap40(input longint v);
        logic signed [39:0] t;
        t = v[39:0];
        return longint'(t);
    endfunction

    function automatic int unsigned lattice_hash(input longint ip, input longint unsigned prime);
        longint unsigned f;
        f = (longint'(ip) * PHI48) & FRAC48;
        return int'((prime * f) >> 48);
    endfunction

    function automatic longint bend(input longint f);
        longint g;
        g = 65536 - f;
        if (f > 32768) return 65536 - ((g * g) >>> 15);
        return (f * f) >>> 15;
    endfunction

    function automatic longint corner(input int unsigned i);
        return longint'(value_table[i % lvnt_pkg::TABLE_DEPTH]);
    endfunction

    // noise at a Q24.16 point, Q.31 result
    function automatic longint lattice_noise(input longint px, input longint py, input longint pz);
        longint p [3];
        longint unsigned primes [3];
        int unsigned h [3][2];
        longint w [3];
        longint ax [2][2];
        longint ay [2];
        longint ip;
        p[0] = px; p[1] = py; p[2] = pz;
        primes[0] = 173; primes[1] = 263; primes[2] = 337;
        for (int k = 0; k < 3; k++) begin
            ip = p[k] >>> 16;
            h[k][0] = lattice_hash(ip, primes[k]);
            h[k][1] = lattice_hash(ip + 1, primes[k]);
            w[k] = bend(p[k] & 64'hFFFF);
        end
        for (int dy = 0; dy < 2; dy++)
            for (int dz = 0; dz < 2; dz++)
                ax[dy][dz] = corner(h[0][0] + h[1][dy] + h[2][dz]) * (65536 - w[0])
                           + corner(h[0][1] + h[1][dy] + h[2][dz]) * w[0];
        for (int dz = 0; dz < 2; dz++)
            ay[dz] = (ax[0][dz] * (65536 - w[1]) + ax[1][dz] * w[1]) >>> 16;
        return (ay[0] * (65536 - w[2]) + ay[1] * w[2]) >>> 16;
    endfunction

    function automatic void vector_noise(input longint p [3], output longint v [3]);
        longint t [3];
        v[0] = lattice_noise(p[0], p[1], p[2]);
        t[0] = wrap40(p[1] + (longint'(173) << 16));
        t[1] = wrap40(p[0] + (longint'(263) << 16));
        t[2] = wrap40(p[2] + (longint'(337) << 16));
        v[1] = lattice_noise(t[0], t[1], t[2]);
        t[0] = wrap40(t[0] + (longint'(263) << 16));
        t[1] = wrap40(t[1] + (longint'(337) << 16));
        t[2] = wrap40(t[2] + (longint'(173) << 16));
        v[2] = lattice_noise(t[0], t[1], t[2]);
    endfunction

    function automatic t_noise_res predict_noise(input t_noise_req rq);
        longint p [3];
        longint t [3];
        longint v [3];
        longint r [3];
        longint acc [3];
        longint c;
        int n;
        t_noise_res res;
        p[0] = longint'(rq.x); p[1] = longint'(rq.y); p[2] = longint'(rq.z);
        r = '{0, 0, 0};
        acc = '{0, 0, 0};
        case (rq.op) inside
            lvnt_pkg::OP_LOAD: value_table[rq.idx % lvnt_pkg::TABLE_DEPTH] = rq.val;
            lvnt_pkg::OP_NOISE: r[0] = lattice_noise(p[0], p[1], p[2]) >>> 15;
            lvnt_pkg::OP_VEC: begin
                vector_noise(p, v);
                for (int k = 0; k < 3; k++) r[k] = v[k] >>> 15;
            end
            lvnt_pkg::OP_GRAD: begin
                c = lattice_noise(p[0], p[1], p[2]);
                for (int k = 0; k < 3; k++) begin
                    t = p;
                    t[k] = wrap40(t[k] + 6554);
                    r[k] = ((lattice_noise(t[0], t[1], t[2]) - c) * 10) >>> 15;
                end
            end
            lvnt_pkg::OP_TURB, lvnt_pkg::OP_VTURB: begin
                n = (rq.oct > lvnt_pkg::MAX_OCTAVES) ? lvnt_pkg::MAX_OCTAVES : int'(rq.oct);
                for (int lvl = 0; lvl < n; lvl++) begin
                    if (rq.op == lvnt_pkg::OP_TURB) begin
                        acc[0] += lattice_noise(p[0], p[1], p[2])
                                  << (lvnt_pkg::MAX_OCTAVES - 1 - lvl);
                    end else begin
                        vector_noise(p, v);
                        for (int k = 0; k < 3; k++)
                            acc[k] += v[k] << (lvnt_pkg::MAX_OCTAVES - 1 - lvl);
                    end
                    for (int k = 0; k < 3; k++) p[k] = wrap40(p[k] * 2);
                end
                for (int k = 0; k < 3; k++)
                    r[k] = acc[k] >>> (15 + lvnt_pkg::MAX_OCTAVES - 1);
            end
            default: ;
        endcase
        res.vx = r[0][31:0];
        res.vy = r[1][31:0];
        res.vz = r[2][31:0];
        return res;
    endfunction

    task automatic send_transaction(input t_noise_req rq, input bit typed, input t_noise_res want);
        t_noise_res res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        res = predict_noise(rq);
        if (typed) res = want;
        i_valid       <= 1'b1;
        i_op          <= rq.op;
        i_table_index <= rq.idx;
        i_table_value <= rq.val;
        i_coord_x     <= rq.x;
        i_coord_y     <= rq.y;
        i_coord_z     <= rq.z;
        i_octaves     <= rq.oct;
        do @(posedge i_clk); while (o_stall);
        pending_values.push_back(res);
    endtask

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{16{1'b0}}, 16'h8000} + $urandom_range(0, 2) - 1;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic t_noise_req random_request();
        t_noise_req rq;
        int pick;
        pick = $urandom_range(99);
        rq.op  = pick < 15 ? lvnt_pkg::OP_LOAD : pick < 35 ? lvnt_pkg::OP_NOISE :
                 pick < 50 ? lvnt_pkg::OP_VEC : pick < 64 ? lvnt_pkg::OP_GRAD :
                 pick < 80 ? lvnt_pkg::OP_TURB : pick < 92 ? lvnt_pkg::OP_VTURB :
                 (pick[0] ? OP_SPARE6 : OP_SPARE7);
        rq.idx = 9'($urandom);
        rq.val = 16'($signed($urandom_range(0, 32768)) - 16384);
        rq.x   = random_coord();
        rq.y   = random_coord();
        rq.z   = random_coord();
        rq.oct = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
        return rq;
    endfunction

    always @(posedge i_clk) begin
        t_noise_res want;
        if (o_valid && !i_stall) begin
            if (pending_values.size() == 0) begin
                report_mismatch("unexpected transaction", o_value_x, 0);
            end else begin
                want = pending_values.pop_front();
                if (o_value_x !== want.vx) report_mismatch("value_x", o_value_x, want.vx);
                if (o_value_y !== want.vy) report_mismatch("value_y", o_value_y, want.vy);
                if (o_value_z !== want.vz) report_mismatch("value_z", o_value_z, want.vz);
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        t_vector_row rows [$];
        t_noise_res zero_res;
        t_noise_req rq;
        zero_res = '{0, 0, 0};
        rows = '{
            '{'{lvnt_pkg::OP_LOAD, 9'd0, -16'sd16384, 0, 0, 0, 0}, 1, zero_res},
            '{'{lvnt_pkg::OP_LOAD, 9'd511, 16'sd16384, 0, 0, 0, 0}, 1, zero_res},
            '{'{lvnt_pkg::OP_NOISE, 0, 0, 0, 0, 0, 0}, 0, zero_res},
            '{'{lvnt_pkg::OP_NOISE, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0},
              0, zero_res},
            '{'{lvnt_pkg::OP_NOISE, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0},
              0, zero_res},
            '{'{lvnt_pkg::OP_NOISE, 0, 0, 32'sh0000_8000, 32'sh0000_8001, -32'sh0000_8000, 0},
              0, zero_res},
            '{'{lvnt_pkg::OP_VEC, 0, 0, 32'sh0001_4000, -32'sh0003_2000, 32'sh7FFF_0000, 0},
              0, zero_res},
            '{'{lvnt_pkg::OP_GRAD, 0, 0, 32'sh0002_7777, 32'sh0000_FFFF, -32'sh0000_0001, 0},
              0, zero_res},
            '{'{lvnt_pkg::OP_GRAD, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0}, 0, zero_res},
            '{'{lvnt_pkg::OP_TURB, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 4'd0},
              1, zero_res},
            '{'{lvnt_pkg::OP_TURB, 0, 0, 32'sh0001_1234, 32'sh0002_5678, 32'sh0003_9ABC, 4'd1},
              0, zero_res},
            '{'{lvnt_pkg::OP_TURB, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0000, 4'd8},
              0, zero_res},
            '{'{lvnt_pkg::OP_TURB, 0, 0, 32'sh0000_8000, 32'sh0000_4000, 32'sh0000_C000, 4'd15},
              0, zero_res},
            '{'{lvnt_pkg::OP_VTURB, 0, 0, 32'sh0005_0000, -32'sh0005_0000, 32'sh0000_1000, 4'd0},
              1, zero_res},
            '{'{lvnt_pkg::OP_VTURB, 0, 0, 32'sh0005_0000, -32'sh0005_0000, 32'sh0000_1000, 4'd8},
              0, zero_res},
            '{'{lvnt_pkg::OP_VTURB, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 4'd9},
              0, zero_res},
            '{'{OP_SPARE6, 9'd5, 16'sd100, 32'sh0001_0000, 0, 0, 4'd3}, 1, zero_res},
            '{'{OP_SPARE7, 9'd6, -16'sd100, 0, 32'sh0001_0000, 0, 4'd3}, 1, zero_res}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table before any evaluation reads it
        for (int i = 0; i < lvnt_pkg::TABLE_DEPTH; i++) begin
            rq = '{lvnt_pkg::OP_LOAD, i[8:0], 16'($signed($urandom_range(0, 32768)) - 16384),
                   0, 0, 0, 0};
            send_transaction(rq, 1'b1, zero_res);
        end
        foreach (rows[i]) send_transaction(rows[i].req, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 36 : 0;
            for (int n = 0; n < 430; n++) send_transaction(random_request(), 1'b0, zero_res);
            // hold until every result is back
            i_valid <= 1'b0;
            wait (pending_values.size() == 0);
            @(posedge i_clk);
        end

        i_valid <= 1'b0;
        wait (pending_values.size() == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== lattice_value_noise_turbulence.f =====
hw/rtl/lvnt_pkg.sv
hw/rtl/lvnt_front.sv
hw/rtl/lvnt_back.sv
hw/rtl/lattice_value_noise_turbulence.sv
tb/sv/tb_lattice_value_noise_turbulence.sv
